### hdl/ssa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and fixed constants of the slab slot allocator: field widths,
// result and status codes, request modes and register indexes.
// ----------------------------------------------------------------------------
package ssa_pkg;

   // fixed field widths
   localparam int ADDR_W     = 16;
   localparam int PAGE_IDX_W = 4;
   localparam int COUNT_W    = 8;
   localparam int ESIZE_W    = 12;
   localparam int HDR_W      = 11;
   localparam int HDR_RND_W  = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // smallest element and header alignment
   localparam int MIN_ELEMENT = 16;
   localparam int HDR_ALIGN   = 16;

   // reset values of the registers
   localparam logic [ESIZE_W-1:0] ELEM_BYTES_RESET   = 12'd16;
   localparam logic [HDR_W-1:0]   HEADER_BYTES_RESET = 11'd32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_BYTES   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 1'b1;

   // saturation point of the per-page counts
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_FREE  = 2'd2
   } status_type;

   // one result word
   typedef struct packed {
      logic [ADDR_W-1:0]     address;
      logic [PAGE_IDX_W-1:0] page_index;
      logic [COUNT_W-1:0]    page_in_use;
      status_type            status;
   } result_type;

endpackage : ssa_pkg
`default_nettype wire

### hdl/ssa_stack_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_stack_mem
// Free stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssa_stack_mem #(
   parameter int DEPTH  = 4096,
   parameter int AW     = 12,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] stack_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ssa_stack_mem
`default_nettype wire

### hdl/ssa_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_core
// Allocator state (stack count, open pages, fresh offset, per-page counts)
// and the combinational decision for one request word.
// ----------------------------------------------------------------------------
module ssa_core #(
   parameter int MAX_PAGES   = 16,
   parameter int PAGE_BYTES  = 4096,
   parameter int STACK_DEPTH = 4096,
   parameter int SA_W        = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          commit,
   input  wire ssa_pkg::mode_type             mode,
   input  wire logic [ssa_pkg::ADDR_W-1:0]    free_address,
   input  wire logic [ssa_pkg::ESIZE_W-1:0]   elem_bytes,
   input  wire logic [ssa_pkg::HDR_W-1:0]     header_bytes,
   input  wire logic [ssa_pkg::ADDR_W-1:0]    pop_data,
   output logic      [SA_W-1:0]               pop_addr,
   output logic                               push_en,
   output logic      [SA_W-1:0]               push_addr,
   output logic      [ssa_pkg::ADDR_W-1:0]    push_data,
   output ssa_pkg::result_type                result
);
   import ssa_pkg::*;

   localparam int PAGE_W    = $clog2(PAGE_BYTES);
   localparam int HALF_PAGE = PAGE_BYTES / 2;
   localparam int OFF_W     = (PAGE_W + 1 > HDR_RND_W) ? PAGE_W + 1 : HDR_RND_W;
   localparam int SUM_W     = OFF_W + 1;
   localparam int PO_W      = $clog2(MAX_PAGES + 1);
   localparam int CI_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int SC_W      = $clog2(STACK_DEPTH + 1);

   logic [SC_W-1:0]    stack_count_ff, stack_count_in;
   logic [PO_W-1:0]    pages_opened_ff, pages_opened_in;
   logic [OFF_W-1:0]   fresh_offset_ff, fresh_offset_in;
   logic [COUNT_W-1:0] page_counts_ff [MAX_PAGES];
   logic [COUNT_W-1:0] page_count_in;
   logic               count_we;

   logic [SUM_W-1:0]     size_eff, elem_ext, hdr_ext, fresh_end, hdr_end;
   logic [HDR_RND_W-1:0] hdr_round;
   logic                 need_open, exhausted, stack_empty;
   logic [PO_W-1:0]      pages_new, fresh_page;
   logic [OFF_W-1:0]     offset_use;
   logic [31:0]          alloc_wide;
   logic [ADDR_W-1:0]    alloc_addr, pop_page, free_page, alloc_page, sel_page;
   logic                 pop_in_range, free_in_range;
   logic [CI_W-1:0]      count_idx;
   logic [COUNT_W-1:0]   count_cur, count_inc, count_dec;
   logic [SC_W-1:0]      pop_count;

   // effective element size clamped to 16 .. half a page
   always_comb begin
      elem_ext = SUM_W'(elem_bytes);
      priority if (elem_ext < SUM_W'(MIN_ELEMENT)) begin
         size_eff = SUM_W'(MIN_ELEMENT);
      end else if (elem_ext > SUM_W'(HALF_PAGE)) begin
         size_eff = SUM_W'(HALF_PAGE);
      end else begin
         size_eff = elem_ext;
      end
   end

   // header rounded up to a multiple of 16
   assign hdr_round = ({1'b0, header_bytes} + HDR_RND_W'(HDR_ALIGN - 1))
                      & ~HDR_RND_W'(HDR_ALIGN - 1);
   assign hdr_ext   = SUM_W'(hdr_round);

   // fresh slot and page opening
   assign stack_empty = (stack_count_ff == '0);
   assign fresh_end   = SUM_W'(fresh_offset_ff) + size_eff;
   assign hdr_end     = hdr_ext + size_eff;
   assign need_open   = (pages_opened_ff == '0) || (fresh_end > SUM_W'(PAGE_BYTES));
   assign exhausted   = need_open && ((pages_opened_ff >= PO_W'(MAX_PAGES))
                                      || (hdr_end > SUM_W'(PAGE_BYTES)));
   assign pages_new   = need_open ? pages_opened_ff + PO_W'(1) : pages_opened_ff;
   assign fresh_page  = pages_new - PO_W'(1);
   assign offset_use  = need_open ? OFF_W'(hdr_round) : fresh_offset_ff;
   assign alloc_wide  = (32'(fresh_page) << PAGE_W) + 32'(offset_use);
   assign alloc_addr  = alloc_wide[ADDR_W-1:0];
   assign alloc_page  = alloc_addr >> PAGE_W;

   // page numbers of popped and freed addresses
   assign pop_page      = pop_data >> PAGE_W;
   assign free_page     = free_address >> PAGE_W;
   assign pop_in_range  = (pop_page < ADDR_W'(MAX_PAGES));
   assign free_in_range = (free_page < ADDR_W'(MAX_PAGES))
                          && (free_page < ADDR_W'(pages_opened_ff));

   // at most one page count is touched per word
   always_comb begin
      priority if (mode == MODE_FREE) begin
         sel_page = free_page;
      end else if (!stack_empty) begin
         sel_page = pop_page;
      end else begin
         sel_page = ADDR_W'(fresh_page);
      end
   end

   assign count_idx = sel_page[CI_W-1:0];
   assign count_cur = page_counts_ff[count_idx];
   assign count_inc = (count_cur == COUNT_MAX) ? count_cur : count_cur + COUNT_W'(1);
   assign count_dec = count_cur - COUNT_W'(1);

   // stack addresses: top entry for a pop, next free entry for a push
   assign pop_count = stack_count_ff - SC_W'(1);
   assign pop_addr  = pop_count[SA_W-1:0];
   assign push_addr = stack_count_ff[SA_W-1:0];
   assign push_data = free_address;

   // decision for the current word
   always_comb begin
      stack_count_in  = stack_count_ff;
      pages_opened_in = pages_opened_ff;
      fresh_offset_in = fresh_offset_ff;
      page_count_in   = count_cur;
      count_we        = 1'b0;
      push_en         = 1'b0;
      result          = '{address: '0, page_index: '0, page_in_use: '0, status: STATUS_OK};

      if (mode == MODE_ALLOC) begin
         priority if (!stack_empty) begin
            // reuse the last freed address
            stack_count_in    = pop_count;
            result.address    = pop_data;
            result.page_index = pop_page[PAGE_IDX_W-1:0];
            if (pop_in_range) begin
               count_we           = 1'b1;
               page_count_in      = count_inc;
               result.page_in_use = count_inc;
            end
         end else if (exhausted) begin
            result.status = STATUS_EXHAUSTED;
         end else begin
            // next fresh slot, opening a page if needed
            pages_opened_in    = pages_new;
            fresh_offset_in    = OFF_W'(SUM_W'(offset_use) + size_eff);
            result.address     = alloc_addr;
            result.page_index  = alloc_page[PAGE_IDX_W-1:0];
            count_we           = 1'b1;
            page_count_in      = count_inc;
            result.page_in_use = count_inc;
         end
      end else begin
         result.address    = free_address;
         result.page_index = free_page[PAGE_IDX_W-1:0];
         priority if (!free_in_range || (count_cur == '0)) begin
            result.status = STATUS_BAD_FREE;
         end else begin
            count_we           = 1'b1;
            page_count_in      = count_dec;
            result.page_in_use = count_dec;
            // a full stack drops the address
            if (stack_count_ff < SC_W'(STACK_DEPTH)) begin
               push_en        = commit;
               stack_count_in = stack_count_ff + SC_W'(1);
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff  <= '0;
         pages_opened_ff <= '0;
         fresh_offset_ff <= '0;
      end else if (commit) begin
         stack_count_ff  <= stack_count_in;
         pages_opened_ff <= pages_opened_in;
         fresh_offset_ff <= fresh_offset_in;
      end
   end

   // per-page counts, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PAGES; i++) begin
            page_counts_ff[i] <= '0;
         end
      end else if (commit && count_we) begin
         page_counts_ff[count_idx] <= page_count_in;
      end
   end

endmodule : ssa_core
`default_nettype wire

### hdl/slab_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_slot_allocator
// Slab style allocator of fixed-size elements in a pool of pages.
// ----------------------------------------------------------------------------
// One request word is taken at a time: no new request is taken until the
// result word of the last one is written to the result register. The top
// entry of the free stack memory is read at acceptance and the registered
// read data is used in the update cycle, when the result word is written
// and the stack count, page state and page counts are updated. A new
// request is taken while an earlier result still waits in the result
// register; a result that is not taken holds the next word in its update
// cycle. No clearing pass is needed after reset: only stack entries below the
// count are read, and the page counts are cleared at once. Register writes
// are taken in any cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
module slab_slot_allocator #(
   parameter int MAX_PAGES   = 16,
   parameter int PAGE_BYTES  = 4096,
   parameter int STACK_DEPTH = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_mode,
   input  wire logic [ssa_pkg::ADDR_W-1:0]      req_free_address,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [ssa_pkg::ADDR_W-1:0]      rsp_address,
   output logic      [ssa_pkg::PAGE_IDX_W-1:0]  rsp_page_index,
   output logic      [ssa_pkg::COUNT_W-1:0]     rsp_page_in_use,
   output logic      [1:0]                      rsp_status,
   // register write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [ssa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ssa_pkg::*;

   localparam int SA_W = $clog2(STACK_DEPTH);

   logic                busy_ff, busy_in;
   mode_type            mode_ff;
   logic [ADDR_W-1:0]   free_address_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, result;
   logic [ESIZE_W-1:0]  elem_bytes_ff;
   logic [HDR_W-1:0]    header_bytes_ff;
   logic                accept, commit;
   logic [SA_W-1:0]     pop_addr, push_addr;
   logic [ADDR_W-1:0]   pop_data, push_data;
   logic                push_en;

   // handshake
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign commit    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request word register
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff         <= mode_type'(req_mode);
         free_address_ff <= req_free_address;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= result;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_bytes_ff   <= ELEM_BYTES_RESET;
         header_bytes_ff <= HEADER_BYTES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ELEM_BYTES: begin
               elem_bytes_ff <= csr_data[ESIZE_W-1:0];
            end
            CSR_HEADER_BYTES: begin
               header_bytes_ff <= csr_data[HDR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // free stack, top read at acceptance
   ssa_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .AW     (SA_W),
      .DATA_W (ADDR_W)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (push_addr),
      .wr_data (push_data),
      .rd_en   (accept),
      .rd_addr (pop_addr),
      .rd_data (pop_data)
   );

   // allocator state and decision
   ssa_core #(
      .MAX_PAGES   (MAX_PAGES),
      .PAGE_BYTES  (PAGE_BYTES),
      .STACK_DEPTH (STACK_DEPTH),
      .SA_W        (SA_W)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .mode         (mode_ff),
      .free_address (free_address_ff),
      .elem_bytes   (elem_bytes_ff),
      .header_bytes (header_bytes_ff),
      .pop_data     (pop_data),
      .pop_addr     (pop_addr),
      .push_en      (push_en),
      .push_addr    (push_addr),
      .push_data    (push_data),
      .result       (result)
   );

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_address     = rsp_ff.address;
   assign rsp_page_index  = rsp_ff.page_index;
   assign rsp_page_in_use = rsp_ff.page_in_use;
   assign rsp_status      = rsp_ff.status;

endmodule : slab_slot_allocator
`default_nettype wire
